FILE: src/tea_pkg.sv
// Shared constants and types for the TEA block cipher core.
package tea_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROUND_W = 24;
  localparam int unsigned CIDX_W  = 3;

  // TEA key schedule constant
  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_ROUNDS = 3'd4
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture a new input beat
    logic step;      // run one full round
    logic out_load;  // move the finished block to the output register
  } tea_cmd_t;

endpackage

FILE: src/tea_block_cipher_core.sv
// Top level of the TEA block cipher core: config registers, controller, datapath.
//
// TEA cipher for one 64-bit block (block_lo = v0, block_hi = v1) under a
// 128-bit key and a programmable round count (default 32). in_mode selects
// encrypt (0) or decrypt (1). One iterative round unit runs one full round
// (both half-rounds) per clock; the next item is accepted once the current
// item's rounds are done and its result can move to the output register. A
// round count of zero passes the block through unchanged, and a beat can then
// be taken every cycle while the output is not stalled. The result sits in an
// output register, so a new beat may be accepted in the same cycle the
// previous result moves there, while that result still waits on out_stall.
// Key and round count must only be written while the core is idle; cfg_ready
// is always high and writes to unknown indexes are dropped. No state is kept
// between items.
module tea_block_cipher_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [tea_pkg::WORD_W-1:0]    in_block_lo,
  input  logic [tea_pkg::WORD_W-1:0]    in_block_hi,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tea_pkg::WORD_W-1:0]    out_result_lo,
  output logic [tea_pkg::WORD_W-1:0]    out_result_hi,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tea_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]    cfg_data
);

  logic [tea_pkg::WORD_W-1:0]   key0_r, key0_nxt;
  logic [tea_pkg::WORD_W-1:0]   key1_r, key1_nxt;
  logic [tea_pkg::WORD_W-1:0]   key2_r, key2_nxt;
  logic [tea_pkg::WORD_W-1:0]   key3_r, key3_nxt;
  logic [tea_pkg::ROUND_W-1:0]  rounds_r, rounds_nxt;
  tea_pkg::tea_cmd_t            cmd;
  logic                         cfg_we;

  localparam logic [tea_pkg::ROUND_W-1:0] ROUNDS_RESET = 24'd32;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // register file write; unused indexes fall through
  always_comb begin
    key0_nxt   = key0_r;
    key1_nxt   = key1_r;
    key2_nxt   = key2_r;
    key3_nxt   = key3_r;
    rounds_nxt = rounds_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tea_pkg::CFG_KEY0:   key0_nxt   = cfg_data;
        tea_pkg::CFG_KEY1:   key1_nxt   = cfg_data;
        tea_pkg::CFG_KEY2:   key2_nxt   = cfg_data;
        tea_pkg::CFG_KEY3:   key3_nxt   = cfg_data;
        tea_pkg::CFG_ROUNDS: rounds_nxt = cfg_data[tea_pkg::ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r   <= '0;
      key1_r   <= '0;
      key2_r   <= '0;
      key3_r   <= '0;
      rounds_r <= ROUNDS_RESET;
    end else begin
      key0_r   <= key0_nxt;
      key1_r   <= key1_nxt;
      key2_r   <= key2_nxt;
      key3_r   <= key3_nxt;
      rounds_r <= rounds_nxt;
    end
  end

  tea_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .round_count (rounds_r),
    .cmd         (cmd)
  );

  tea_datapath u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .in_mode       (in_mode),
    .in_block_lo   (in_block_lo),
    .in_block_hi   (in_block_hi),
    .key_word0     (key0_r),
    .key_word1     (key1_r),
    .key_word2     (key2_r),
    .key_word3     (key3_r),
    .round_count   (rounds_r),
    .out_result_lo (out_result_lo),
    .out_result_hi (out_result_hi)
  );

  // a beat with rounds to run keeps the input stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && rounds_r != '0) |=> in_stall)
    else $error("input not stalled while rounds are running");

  // single round: once the round state is passed, the core is free again unless the output is blocked
  a_single_round_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && rounds_r == 24'd1) |=> ##1 (in_stall == (out_valid && out_stall)))
    else $error("single-round item did not finish on time");

  // reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

FILE: src/tea_ctrl.sv
// Controller: sequences load, rounds and result hand-off.
module tea_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  logic [tea_pkg::ROUND_W-1:0]     round_count,
  output tea_pkg::tea_cmd_t               cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  localparam logic [tea_pkg::ROUND_W-1:0] ROUND_ONE = 24'd1;

  state_t                        state_r, state_nxt;
  logic [tea_pkg::ROUND_W-1:0]   count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          slot_free;
  logic                          accept;
  logic                          zero_rounds;

  assign slot_free   = !out_valid_r || !out_stall;
  assign zero_rounds = (round_count == '0);
  assign in_stall    = !((state_r == ST_IDLE) || ((state_r == ST_DONE) && slot_free));
  assign accept      = in_valid && !in_stall;
  assign out_valid   = out_valid_r;

  assign cmd.load     = accept;
  assign cmd.step     = (state_r == ST_ROUND);
  assign cmd.out_load = (state_r == ST_DONE) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = zero_rounds ? ST_DONE : ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (count_r == ROUND_ONE) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (accept) begin
          state_nxt = zero_rounds ? ST_DONE : ST_ROUND;
        end else if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = round_count;
    end else if (state_r == ST_ROUND) begin
      count_nxt = count_r - ROUND_ONE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/tea_datapath.sv
// Datapath: block halves, running sum, round function and output register.
module tea_datapath (
  input  logic                           clk,
  input  tea_pkg::tea_cmd_t              cmd,
  input  logic                           in_mode,
  input  logic [tea_pkg::WORD_W-1:0]     in_block_lo,
  input  logic [tea_pkg::WORD_W-1:0]     in_block_hi,
  input  logic [tea_pkg::WORD_W-1:0]     key_word0,
  input  logic [tea_pkg::WORD_W-1:0]     key_word1,
  input  logic [tea_pkg::WORD_W-1:0]     key_word2,
  input  logic [tea_pkg::WORD_W-1:0]     key_word3,
  input  logic [tea_pkg::ROUND_W-1:0]    round_count,
  output logic [tea_pkg::WORD_W-1:0]     out_result_lo,
  output logic [tea_pkg::WORD_W-1:0]     out_result_hi
);

  logic                          mode_r, mode_nxt;
  logic [tea_pkg::WORD_W-1:0]    v0_r, v0_nxt;
  logic [tea_pkg::WORD_W-1:0]    v1_r, v1_nxt;
  logic [tea_pkg::WORD_W-1:0]    sum_r, sum_nxt;
  logic [tea_pkg::WORD_W-1:0]    res_lo_r, res_lo_nxt;
  logic [tea_pkg::WORD_W-1:0]    res_hi_r, res_hi_nxt;
  logic [tea_pkg::WORD_W-1:0]    dec_start;
  logic [tea_pkg::WORD_W-1:0]    enc_v0, enc_v1, dec_v0, dec_v1;

  function automatic logic [tea_pkg::WORD_W-1:0] mix(
    input logic [tea_pkg::WORD_W-1:0] x,
    input logic [tea_pkg::WORD_W-1:0] s,
    input logic [tea_pkg::WORD_W-1:0] ka,
    input logic [tea_pkg::WORD_W-1:0] kb
  );
    mix = ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

  // decrypt starts from DELTA * rounds, mod 2^32
  assign dec_start = tea_pkg::WORD_W'(tea_pkg::DELTA * {8'd0, round_count});

  // sum_r already holds the sum for the round in progress
  assign enc_v0 = v0_r + mix(v1_r, sum_r, key_word0, key_word1);
  assign enc_v1 = v1_r + mix(enc_v0, sum_r, key_word2, key_word3);
  assign dec_v1 = v1_r - mix(v0_r, sum_r, key_word2, key_word3);
  assign dec_v0 = v0_r - mix(dec_v1, sum_r, key_word0, key_word1);

  always_comb begin
    mode_nxt = mode_r;
    v0_nxt   = v0_r;
    v1_nxt   = v1_r;
    sum_nxt  = sum_r;
    if (cmd.load) begin
      mode_nxt = in_mode;
      v0_nxt   = in_block_lo;
      v1_nxt   = in_block_hi;
      sum_nxt  = in_mode ? dec_start : tea_pkg::DELTA;
    end else if (cmd.step) begin
      v0_nxt  = mode_r ? dec_v0 : enc_v0;
      v1_nxt  = mode_r ? dec_v1 : enc_v1;
      sum_nxt = mode_r ? (sum_r - tea_pkg::DELTA) : (sum_r + tea_pkg::DELTA);
    end
  end

  always_comb begin
    res_lo_nxt = res_lo_r;
    res_hi_nxt = res_hi_r;
    if (cmd.out_load) begin
      res_lo_nxt = v0_r;
      res_hi_nxt = v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    v0_r     <= v0_nxt;
    v1_r     <= v1_nxt;
    sum_r    <= sum_nxt;
    res_lo_r <= res_lo_nxt;
    res_hi_r <= res_hi_nxt;
  end

  assign out_result_lo = res_lo_r;
  assign out_result_hi = res_hi_r;

endmodule
